// File: rtl/dtlr_pkg.sv
// Shared types, codes and matcher functions for the dual terminator line receiver.
package dtlr_pkg;

    localparam int DTLR_BUFFER_BYTES   = 64;
    localparam int DTLR_TERM_MAX_BYTES = 8;

    // configuration register indexes
    localparam logic [2:0] CFG_FIRST_BYTES  = 3'd0;
    localparam logic [2:0] CFG_FIRST_LEN    = 3'd1;
    localparam logic [2:0] CFG_SECOND_BYTES = 3'd2;
    localparam logic [2:0] CFG_SECOND_LEN   = 3'd3;
    localparam logic [2:0] CFG_IDLE_LIMIT   = 3'd4;

    // request opcodes
    localparam logic [0:0] OP_BYTE = 1'b0;
    localparam logic [0:0] OP_IDLE = 1'b1;

    // message end status codes
    localparam logic [1:0] ST_FIRST    = 2'd0;
    localparam logic [1:0] ST_SECOND   = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;
    localparam logic [1:0] ST_TIMEOUT  = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD,
        S_LD
    } t_state;

    typedef struct packed {
        logic       done;
        logic [3:0] pos;
    } t_match;

    // zero acts as one, anything above the maximum acts as the maximum
    function automatic logic [3:0] f_eff_len(input logic [3:0] len, input logic [3:0] max_len);
        logic [3:0] res;
        if (len == 4'd0) begin
            res = 4'd1;
        end else if (len > max_len) begin
            res = max_len;
        end else begin
            res = len;
        end
        return res;
    endfunction

    // advance one matcher by one byte; a mismatch drops back to zero
    function automatic t_match f_match(input logic [3:0] pos, input logic [63:0] chars,
                                       input logic [3:0] len, input logic [7:0] b);
        t_match     res;
        logic [2:0] idx;
        logic [7:0] want;
        logic [4:0] pos_inc;
        if (pos < len) begin
            idx = pos[2:0];
        end else begin
            idx = 3'(len - 4'd1);
        end
        want     = chars[{idx, 3'b000} +: 8];
        pos_inc  = {1'b0, pos} + 5'd1;
        res.done = (b == want) && (pos_inc >= {1'b0, len});
        res.pos  = (b == want) ? pos_inc[3:0] : 4'd0;
        return res;
    endfunction

endpackage

// File: rtl/dual_terminator_line_receiver.sv
// Dual terminator line receiver: byte buffer, two terminator matchers, idle timeout, flush.
// Flow: a request that ends no message is absorbed with no result; an empty message
//   shows its result the cycle after the request; a message with payload moves each
//   byte through S_RD (memory read) and S_LD (load, waits for a free output register).
// Throughput: 1 request per cycle when idle with a free output; input holds during flush.
// Reset: synchronous active low; session and configuration return to defaults, buffer kept.
module dual_terminator_line_receiver #(
    parameter int BUFFER_BYTES   = dtlr_pkg::DTLR_BUFFER_BYTES,
    parameter int TERM_MAX_BYTES = dtlr_pkg::DTLR_TERM_MAX_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    // receive request channel
    input  logic        i_rx_valid,
    output logic        o_rx_ready,
    input  logic [0:0]  i_opcode,
    input  logic [7:0]  i_rx_byte,
    // message result channel
    output logic        o_msg_valid,
    input  logic        i_msg_ready,
    output logic [1:0]  o_status,
    output logic [7:0]  o_data_byte,
    output logic [0:0]  o_data_valid,
    output logic [0:0]  o_last
);
    import dtlr_pkg::*;

    // buffer holds up to BUFFER_BYTES-1 bytes; count width covers that value
    localparam int         Depth   = BUFFER_BYTES - 1;
    localparam int         AW      = $clog2(Depth);
    localparam int         CW      = $clog2(BUFFER_BYTES);
    localparam int         SW      = (CW > 4) ? CW : 4;
    localparam logic [3:0] TermMax = 4'(TERM_MAX_BYTES);

    // configuration registers
    logic [63:0] r_first_bytes;
    logic [3:0]  r_first_len;
    logic [63:0] r_second_bytes;
    logic [3:0]  r_second_len;
    logic [31:0] r_idle_limit;

    // session state
    logic [CW-1:0] r_byte_cnt, n_byte_cnt;
    logic [3:0]    r_pos1, n_pos1;
    logic [3:0]    r_pos2, n_pos2;
    logic [31:0]   r_idle_cnt, n_idle_cnt;

    // flush control
    t_state        r_state, n_state;
    logic [CW-1:0] r_len, n_len;
    logic [1:0]    r_status, n_status;
    logic [AW-1:0] r_rd_idx;
    logic [7:0]    r_rd_data;

    // payload buffer
    logic [7:0]    r_payload_mem [0:Depth-1];

    // output register
    logic          r_out_valid;
    logic [1:0]    r_out_status;
    logic [7:0]    r_out_data;
    logic          r_out_dv;
    logic          r_out_last;

    logic          w_accept;
    logic          w_out_free;
    logic          w_rd_en;
    logic          w_ld_flush;
    logic          w_flush_last;
    logic          w_wr_en;
    logic          w_end;
    logic [1:0]    w_end_status;
    logic [CW-1:0] w_end_cnt;
    logic [CW-1:0] w_stored;
    logic [3:0]    w_len1;
    logic [3:0]    w_len2;
    logic [SW-1:0] w_sub1;
    logic [SW-1:0] w_sub2;
    logic [31:0]   w_idle_inc;
    t_match        w_m1;
    t_match        w_m2;

    assign w_out_free   = !r_out_valid || i_msg_ready;
    assign w_accept     = i_rx_valid && o_rx_ready;
    assign w_flush_last = ((CW'(r_rd_idx) + CW'(1)) == r_len);

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_bytes  <= 64'd2573;
            r_first_len    <= 4'd2;
            r_second_bytes <= 64'd35;
            r_second_len   <= 4'd1;
            r_idle_limit   <= 32'd100000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FIRST_BYTES:  r_first_bytes  <= i_cfg_data;
                CFG_FIRST_LEN:    r_first_len    <= i_cfg_data[3:0];
                CFG_SECOND_BYTES: r_second_bytes <= i_cfg_data;
                CFG_SECOND_LEN:   r_second_len   <= i_cfg_data[3:0];
                CFG_IDLE_LIMIT:   r_idle_limit   <= i_cfg_data[31:0];
                default: ; // unknown index: drop the write
            endcase
        end
    end

    // ---------------- request decode ----------------
    // Both matchers are evaluated in parallel; the first one has priority, and the
    // second one only advances when the first did not complete.
    assign w_len1     = f_eff_len(r_first_len, TermMax);
    assign w_len2     = f_eff_len(r_second_len, TermMax);
    assign w_m1       = f_match(r_pos1, r_first_bytes, w_len1, i_rx_byte);
    assign w_m2       = f_match(r_pos2, r_second_bytes, w_len2, i_rx_byte);
    assign w_stored   = r_byte_cnt + CW'(1);
    // terminator length never exceeds the bytes seen in this session
    assign w_sub1     = SW'(w_stored) - SW'(w_len1);
    assign w_sub2     = SW'(w_stored) - SW'(w_len2);
    assign w_idle_inc = (r_idle_cnt == '1) ? r_idle_cnt : r_idle_cnt + 32'd1;
    assign w_wr_en    = w_accept && (i_opcode == OP_BYTE);

    always_comb begin
        n_byte_cnt   = r_byte_cnt;
        n_pos1       = r_pos1;
        n_pos2       = r_pos2;
        n_idle_cnt   = r_idle_cnt;
        w_end        = 1'b0;
        w_end_status = ST_FIRST;
        w_end_cnt    = '0;
        if (w_accept) begin
            if (i_opcode == OP_IDLE) begin
                // idle poll: count, time out with an empty message
                n_idle_cnt = w_idle_inc;
                if (w_idle_inc >= r_idle_limit) begin
                    w_end        = 1'b1;
                    w_end_status = ST_TIMEOUT;
                end
            end else begin
                n_idle_cnt = '0;
                if (w_m1.done) begin
                    w_end        = 1'b1;
                    w_end_status = ST_FIRST;
                    w_end_cnt    = w_sub1[CW-1:0];
                end else begin
                    n_pos1 = w_m1.pos;
                    if (w_m2.done) begin
                        w_end        = 1'b1;
                        w_end_status = ST_SECOND;
                        w_end_cnt    = w_sub2[CW-1:0];
                    end else begin
                        n_pos2     = w_m2.pos;
                        n_byte_cnt = w_stored;
                        if (w_stored >= CW'(BUFFER_BYTES - 1)) begin
                            w_end        = 1'b1;
                            w_end_status = ST_OVERFLOW;
                            w_end_cnt    = w_stored;
                        end
                    end
                end
            end
            // a finished message restarts the session
            if (w_end) begin
                n_byte_cnt = '0;
                n_pos1     = '0;
                n_pos2     = '0;
                n_idle_cnt = '0;
            end
        end
    end

    // ---------------- flush state machine ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_end && (w_end_cnt != '0)) begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_LD;
            end
            S_LD: begin
                if (w_out_free) begin
                    n_state = w_flush_last ? S_IDLE : S_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_rx_ready = 1'b0;
        w_rd_en    = 1'b0;
        w_ld_flush = 1'b0;
        unique case (r_state)
            S_IDLE:  o_rx_ready = w_out_free;
            S_RD:    w_rd_en    = 1'b1;
            S_LD:    w_ld_flush = w_out_free;
            default: ;
        endcase
    end

    // latch message length and status when a message ends while idle
    always_comb begin
        n_len    = r_len;
        n_status = r_status;
        if ((r_state == S_IDLE) && w_end) begin
            n_len    = w_end_cnt;
            n_status = w_end_status;
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_byte_cnt <= '0;
            r_pos1     <= '0;
            r_pos2     <= '0;
            r_idle_cnt <= '0;
            r_len      <= '0;
            r_status   <= ST_FIRST;
            r_rd_idx   <= '0;
        end else begin
            r_state    <= n_state;
            r_byte_cnt <= n_byte_cnt;
            r_pos1     <= n_pos1;
            r_pos2     <= n_pos2;
            r_idle_cnt <= n_idle_cnt;
            r_len      <= n_len;
            r_status   <= n_status;
            // rewind on a new flush, advance after each loaded byte
            if (r_state == S_IDLE) begin
                r_rd_idx <= '0;
            end else if (w_ld_flush) begin
                r_rd_idx <= r_rd_idx + AW'(1);
            end
        end
    end

    // ---------------- payload buffer ----------------
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_payload_mem[r_byte_cnt[AW-1:0]] <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_data <= r_payload_mem[r_rd_idx];
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_end && (w_end_cnt == '0)) begin
            r_out_valid <= 1'b1;
        end else if (w_ld_flush) begin
            r_out_valid <= 1'b1;
        end else if (i_msg_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_end && (w_end_cnt == '0)) begin
            // empty message: one result, no payload
            r_out_status <= w_end_status;
            r_out_data   <= 8'd0;
            r_out_dv     <= 1'b0;
            r_out_last   <= 1'b1;
        end else if (w_ld_flush) begin
            r_out_status <= r_status;
            r_out_data   <= r_rd_data;
            r_out_dv     <= 1'b1;
            r_out_last   <= w_flush_last;
        end
    end

    assign o_msg_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_data_byte  = r_out_data;
    assign o_data_valid = r_out_dv;
    assign o_last       = r_out_last;

    // ---------------- assertions ----------------
    a_cnt_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_cnt < CW'(BUFFER_BYTES - 1))
        else $error("byte count reached buffer limit inside a session");

    a_rd_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (CW'(r_rd_idx) < r_len))
        else $error("flush read index beyond message length");

    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos1 < 4'd8) && (r_pos2 < 4'd8))
        else $error("match position out of range");

    a_flush_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_RD) && ($past(r_state) == S_IDLE)) |-> $past(i_rx_valid && o_rx_ready))
        else $error("flush started without an accepted request");

endmodule
